FILE: hw/rtl/extended80_to_double_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the conversion pipeline
// Clocked on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef EXTENDED80_TO_DOUBLE_MACROS_SVH
`define EXTENDED80_TO_DOUBLE_MACROS_SVH

// Same-cycle implication
`define E2D_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define E2D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/e2d_pkg.sv
// ---------------------------------------------------------------------------
// e2d_pkg
// Constants and helpers for the extended-to-double conversion pipeline.
// ---------------------------------------------------------------------------
package e2d_pkg;

    // Exponent rebias: 16383 - 1023
    localparam int unsigned RebiasOff = 15360;
    localparam int unsigned ExpW      = 17;   // signed working exponent
    localparam int unsigned ShW       = 7;    // round shift, 11..65 in use
    localparam logic [10:0] DExpMax   = 11'h7FF;
    localparam int unsigned NormShift = 11;
    localparam int unsigned MaxShift  = 65;

    typedef logic signed [ExpW-1:0] t_exp;

    // Leading zero count of a nonzero 64-bit word (result for zero unused)
    function automatic logic [5:0] lzc64(input logic [63:0] m);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (m[i]) n = 6'(63 - i);
        end
        return n;
    endfunction

endpackage

FILE: hw/rtl/extended80_to_double.sv
// ---------------------------------------------------------------------------
// extended80_to_double
// Four-stage pipeline converting an x87 80-bit extended value to binary64.
// ---------------------------------------------------------------------------
// One item enters per cycle while o_ready is high. Its result is valid on the
// outputs once it has passed the four register stages (leading-zero count,
// normalize, round, pack). Each stage holds its item while the next one is
// full and stalled, so throughput is one per cycle whenever o_ready stays high.
// Exponent 0x7FFF with a nonzero mantissa converts to infinity, never NaN.
module extended80_to_double
    import e2d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_sign_and_exponent,
    input  logic [63:0] i_mantissa,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_double_bits
);
    // stage enables: a stage loads when empty or when its successor moves
    logic w_en1, w_en2, w_en3, w_en4;

    logic r_v1, r_v2, r_v3, r_v4;
    logic r_s1, r_s2, r_s3;
    logic r_z1, r_z2, r_z3;
    logic [14:0] r_e1;
    logic [63:0] r_m1;
    logic [5:0]  r_lz1;
    logic [63:0] r_m2;
    t_exp        r_b2;
    logic [ShW-1:0] r_sh2;
    logic [63:0] r_q3;
    t_exp        r_b3;
    logic [63:0] r_out4;

    t_exp           n_b2;
    logic [ShW-1:0] n_sh2;
    t_exp           w_neg;
    logic [63:0]    w_q;
    logic [63:0]    n_out4;
    logic [52:0]    w_qn;
    t_exp           w_bn;

    assign w_en4   = !r_v4 || i_ready;
    assign w_en3   = !r_v3 || w_en4;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
        end
    end

    // stage 1: capture and count leading zeros
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1  <= i_sign_and_exponent[15];
            r_e1  <= i_sign_and_exponent[14:0];
            r_m1  <= i_mantissa;
            r_z1  <= (i_mantissa == 64'd0);
            r_lz1 <= lzc64(i_mantissa);
        end
    end

    // stage 2: normalize, rebias, pick the round shift
    always_comb begin
        n_b2  = t_exp'({2'b00, r_e1}) - t_exp'(RebiasOff) - t_exp'({11'd0, r_lz1});
        w_neg = t_exp'(12) - n_b2;
        if (n_b2 >= t_exp'(1)) begin
            n_sh2 = ShW'(NormShift);
        end else if (w_neg > t_exp'(MaxShift)) begin
            n_sh2 = ShW'(MaxShift);
        end else begin
            n_sh2 = w_neg[ShW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2  <= r_s1;
            r_z2  <= r_z1;
            r_m2  <= r_m1 << r_lz1;
            r_b2  <= n_b2;
            r_sh2 <= n_sh2;
        end
    end

    // stage 3: round
    e2d_round u_round (
        .i_mant  (r_m2),
        .i_shift (r_sh2),
        .o_q     (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_s3 <= r_s2;
            r_z3 <= r_z2;
            r_q3 <= w_q;
            r_b3 <= r_b2;
        end
    end

    // stage 4: renormalize after carry-out, saturate, pack
    always_comb begin
        w_qn = r_q3[53] ? r_q3[53:1] : r_q3[52:0];
        w_bn = r_q3[53] ? r_b3 + t_exp'(1) : r_b3;
        if (r_z3) begin
            n_out4 = {r_s3, 63'd0};
        end else if (r_b3 >= t_exp'(1)) begin
            if (w_bn >= t_exp'(DExpMax)) begin
                n_out4 = {r_s3, DExpMax, 52'd0};
            end else begin
                n_out4 = {r_s3, w_bn[10:0], w_qn[51:0]};
            end
        end else begin
            n_out4 = {r_s3, r_q3[62:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) r_out4 <= n_out4;
    end

    assign o_valid       = r_v4;
    assign o_double_bits = r_out4;

`include "extended80_to_double_macros.svh"

    `E2D_ASSERT_NOW(a_no_nan, o_valid && (o_double_bits[62:52] == DExpMax), o_double_bits[51:0] == 52'd0, "NaN produced")
    `E2D_ASSERT_NEXT(a_in_lands, i_valid && o_ready, r_v1, "accepted item lost at stage 1")
    `E2D_ASSERT_NEXT(a_s3_holds, r_v3 && !w_en4, r_v3 && $stable(r_q3), "stage 3 lost while stalled")
    `E2D_ASSERT_NOW(a_shift_rng, r_v2, r_sh2 >= ShW'(NormShift) && r_sh2 <= ShW'(MaxShift), "round shift out of range")

endmodule

FILE: hw/rtl/e2d_round.sv
// ---------------------------------------------------------------------------
// e2d_round
// Right shift of a normalized significand with round to nearest even.
// Shift amounts of 65 and above flush to zero.
// ---------------------------------------------------------------------------
module e2d_round
    import e2d_pkg::*;
(
    input  logic [63:0]    i_mant,
    input  logic [ShW-1:0] i_shift,
    output logic [63:0]    o_q
);
    logic [127:0] w_wide;
    logic [63:0]  w_q;
    logic [63:0]  w_frac;
    logic         w_up;

    // upper half is the quotient, lower half the remainder left-aligned
    assign w_wide = {i_mant, 64'd0} >> i_shift;
    assign w_q    = w_wide[127:64];
    assign w_frac = w_wide[63:0];
    assign w_up   = (w_frac > {1'b1, 63'd0}) ||
                    ((w_frac == {1'b1, 63'd0}) && w_q[0]);

    always_comb begin
        if (i_shift > ShW'(64)) begin
            o_q = 64'd0;
        end else begin
            o_q = w_q + {63'd0, w_up};
        end
    end
endmodule

FILE: verif/extended80_to_double_test.sv
// ---------------------------------------------------------------------------
// extended80_to_double_test
// Drives 80-bit extended values into the converter through a valid/ready
// transfer, predicts each binary64 pattern with an integer model of the
// rounding, and compares every result in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module extended80_to_double_test;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [15:0] i_sign_and_exponent;
    logic [63:0] i_mantissa;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_double_bits;

    localparam int XBias   = 16383;
    localparam int DBias   = 1023;
    localparam int DExpTop = 2047;
    localparam int CycleLimit = 400000;

    logic [63:0] expected_doubles[$];
    int          mismatches;
    bit          src_idle_on;
    bit          sink_idle_on;
    longint      cycles;

    extended80_to_double dut (.*);

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Nearest-even right shift; shifts of 65 or more give zero
    function automatic logic [63:0] shift_round(logic [63:0] m, int s);
        logic [63:0] q, rem, half;
        if (s > 64) return 64'd0;
        if (s == 64) begin
            q = 64'd0; rem = m; half = 64'h8000_0000_0000_0000;
        end else begin
            q = m >> s;
            rem = m & ((64'd1 << s) - 64'd1);
            half = 64'd1 << (s - 1);
        end
        if (rem > half || (rem == half && q[0])) q = q + 64'd1;
        return q;
    endfunction

    // Predicted binary64 pattern for one extended value
    function automatic logic [63:0] convert_extended(logic [15:0] se, logic [63:0] m);
        logic [63:0] sgn, q;
        int lz, b;
        sgn = {se[15], 63'd0};
        if (m == 64'd0) return sgn;
        lz = 0;
        while (!m[63]) begin
            m = m << 1;
            lz++;
        end
        b = int'(se[14:0]) - XBias - lz + DBias;
        if (b >= 1) begin
            q = shift_round(m, 11);
            if (q[53]) begin
                q = q >> 1;
                b++;
            end
            if (b >= DExpTop) return sgn | (64'(DExpTop) << 52);
            return sgn | (64'(b) << 52) | (q & ((64'd1 << 52) - 64'd1));
        end
        return sgn | shift_round(m, (12 - b) > 65 ? 65 : 12 - b);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatches++;
    endtask

    // Send one value; the expectation is queued at acceptance.
    // Valid stays high after the transfer until the next idle cycle or drain.
    task automatic send_value(logic [15:0] se, logic [63:0] m);
        while (src_idle_on && $urandom_range(99) < 32) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_sign_and_exponent <= se;
        i_mantissa <= m;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_doubles.push_back(convert_extended(se, m));
        @(negedge i_clk);
    endtask

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_doubles.size() == 0)
                report_mismatch("unexpected result", o_double_bits, 64'd0);
            else if (o_double_bits !== expected_doubles[0])
                report_mismatch("double_bits", o_double_bits, expected_doubles.pop_front());
            else
                void'(expected_doubles.pop_front());
        end
    end

    // Sink stalls
    always @(negedge i_clk) begin
        i_ready <= sink_idle_on ? ($urandom_range(99) >= 32) : 1'b1;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_doubles.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Directed corners: zeros, extremes, unnormals, overflow, underflow, ties
    task automatic test_corners();
        send_value(16'h0000, 64'd0);
        send_value(16'hFFFF, 64'd0);
        send_value(16'h7FFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_value(16'hFFFF, 64'h8000_0000_0000_0000);
        send_value(16'h0000, 64'h8000_0000_0000_0000);
        send_value(16'h8000, 64'd1);
        send_value(16'h3FFF, 64'h8000_0000_0000_0000);
        send_value(16'hBFFF, 64'h0000_0000_0000_0001);
        send_value(16'h43FE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_value(16'h43FE, 64'hFFFF_FFFF_FFFF_F800);
        send_value(16'h43FE, 64'hFFFF_FFFF_FFFF_F7FF);
        send_value(16'h3FFF, 64'h8000_0000_0000_0400);
        send_value(16'h3FFF, 64'h8000_0000_0000_0C00);
        send_value(16'h3C01, 64'h8000_0000_0000_0000);
        send_value(16'h3C00, 64'hFFFF_FFFF_FFFF_FC00);
        send_value(16'h3BCD, 64'h8000_0000_0000_0000);
        send_value(16'h3BCC, 64'h8000_0000_0000_0000);
        send_value(16'h3BCC, 64'h8000_0000_0000_0001);
        send_value(16'hBBCB, 64'hFFFF_FFFF_FFFF_FFFF);
        send_value(16'h3FFF, 64'h4000_0000_0000_0000);
        send_value(16'h4000, 64'h5555_5555_5555_5555);
    endtask

    // Exponents spread around the double range, with random content
    task automatic test_random(int count);
        logic [15:0] se;
        logic [63:0] m;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(4))
                0: se = 16'($urandom);
                1: se = {1'($urandom), 15'($urandom_range(15300, 17470))};
                default: se = {1'($urandom), 15'($urandom_range(15290, 15370))};
            endcase
            m = rand64();
            if ($urandom_range(3) == 0) m = m >> $urandom_range(63);
            if ($urandom_range(7) == 0) m[10:0] = 11'h400;
            send_value(se, m);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_sign_and_exponent = 16'd0;
        i_mantissa = 64'd0;
        mismatches = 0;
        cycles = 0;
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_corners();
        wait_drained();
        test_random(700);
        wait_drained();
        // Full-rate stretch with no idling on either side
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        test_random(300);
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        test_random(400);
        wait_drained();

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/e2d_pkg.sv
hw/rtl/e2d_round.sv
hw/rtl/extended80_to_double.sv
verif/extended80_to_double_test.sv
